// File: rtl/core/rkd_pkg.sv
// Shared types and constants for the RK number decoder.
package rkd_pkg;

    localparam logic [52:0] C_MANT = 53'h1_47AE_147A_E147B;
    localparam logic [26:0] C_HI   = C_MANT[52:26];
    localparam logic [25:0] C_LO   = C_MANT[25:0];
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [1:0]  FLAG_SCALE = 2'd0;
    localparam logic [1:0]  FLAG_INT   = 2'd1;

    typedef struct packed {
        logic               sign;
        logic               scale;
        logic               is_int;
        logic               nan;
        logic               inf;
        logic               zero;
        logic [31:0]        word;
        logic [29:0]        mag;
        logic signed [12:0] ex;
        logic signed [12:0] dn;
        logic [4:0]         lz;
        logic [63:0]        plain;
        logic [56:0]        ph;
        logic [55:0]        pl;
        logic [82:0]        prod;
        logic [52:0]        trunc;
        logic               grd;
        logic               stk;
        logic [10:0]        ebase;
    } t_num;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

endpackage

// File: rtl/core/rkd_unpack.sv
// Decode of the RK word, leading zero count and normalization (three stages).
module rkd_unpack
    import rkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic [31:0] i_word,
    output logic        o_valid,
    output t_num        o_num
);

    logic r_v1, r_v2, r_v3;
    t_num r_s1, r_s2, r_s3;
    t_num n_s1, n_s2, n_s3;

    always_comb begin
        logic [29:0] p;
        logic [10:0] e;
        logic [20:0] m;
        logic [10:0] e_eff;
        n_s1 = '0;
        p = i_word[31:2];
        e = i_word[30:20];
        m = {(e != 11'd0), i_word[19:2], 2'b00};
        e_eff = (e == 11'd0) ? 11'd1 : e;
        n_s1.word = i_word;
        n_s1.scale = i_word[FLAG_SCALE];
        n_s1.is_int = i_word[FLAG_INT];
        n_s1.sign = i_word[31];
        if (i_word[FLAG_INT]) begin
            n_s1.mag = p[29] ? (~p + 30'd1) : p;
            n_s1.ex = 13'sd0;
            n_s1.zero = (p == 30'd0);
        end else begin
            n_s1.mag = {m, 9'b0};
            n_s1.ex = $signed({2'b00, e_eff}) - 13'sd1052;
            n_s1.nan = (e == 11'h7FF) && (i_word[19:2] != 18'd0);
            n_s1.inf = (e == 11'h7FF) && (i_word[19:2] == 18'd0);
            n_s1.zero = (e == 11'd0) && (i_word[19:2] == 18'd0);
        end
    end

    always_comb begin
        n_s2 = r_s1;
        n_s2.lz = 5'd0;
        for (int i = 0; i < 30; i++) begin
            if (r_s1.mag[i]) begin
                n_s2.lz = 5'(29 - i);
            end
        end
    end

    always_comb begin
        logic [29:0] a;
        n_s3 = r_s2;
        a = r_s2.mag << r_s2.lz;
        n_s3.mag = a;
        n_s3.ex = r_s2.ex - $signed({8'b0, r_s2.lz});
        if (r_s2.is_int) begin
            if (r_s2.zero) begin
                n_s3.plain = 64'd0;
            end else begin
                n_s3.plain = {r_s2.sign, 11'd1052 - {6'b0, r_s2.lz}, a[28:0], 23'b0};
            end
        end else begin
            n_s3.plain = {r_s2.word[31:2], 2'b00, 32'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_num   = r_s3;

endmodule

// File: rtl/core/rkd_mul.sv
// Product of the significand with the constant 0.01, in two partial products.
module rkd_mul
    import rkd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_num i_num,
    output logic o_valid,
    output t_num o_num
);

    logic r_v4, r_v5;
    t_num r_s4, r_s5;
    t_num n_s4, n_s5;

    always_comb begin
        n_s4 = i_num;
        n_s4.ph = i_num.mag * C_HI;
        n_s4.pl = i_num.mag * C_LO;
    end

    always_comb begin
        n_s5 = r_s4;
        n_s5.prod = ({26'b0, r_s4.ph} << 26) + {27'b0, r_s4.pl};
        n_s5.dn = -(r_s4.ex + 13'sd1015);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v4 <= i_ctl.valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s4 <= n_s4;
            r_s5 <= n_s5;
        end
    end

    assign o_valid = r_v5;
    assign o_num   = r_s5;

endmodule

// File: rtl/core/rkd_round.sv
// Alignment, rounding to nearest even and selection of special results.
module rkd_round
    import rkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  t_num        i_num,
    output logic        o_valid,
    output logic [63:0] o_bits
);

    logic        r_v6, r_v7;
    t_num        r_s6;
    t_num        n_s6;
    logic [63:0] r_bits;
    logic [63:0] n_bits;

    always_comb begin
        logic signed [12:0] k_min;
        logic signed [12:0] dsel;
        logic signed [12:0] eb;
        logic [6:0]         d;
        logic [6:0]         dm1;
        logic [82:0]        sh;
        logic [82:0]        mask;
        n_s6 = i_num;
        k_min = i_num.prod[82] ? 13'sd30 : 13'sd29;
        dsel = (i_num.dn > k_min) ? i_num.dn : k_min;
        d = dsel[6:0];
        dm1 = d - 7'd1;
        sh = i_num.prod >> d;
        mask = (83'd1 << dm1) - 83'd1;
        eb = k_min + i_num.ex + 13'sd1015;
        n_s6.trunc = sh[52:0];
        n_s6.grd = i_num.prod[dm1];
        n_s6.stk = |(i_num.prod & mask);
        n_s6.ebase = (dsel == k_min) ? eb[10:0] : 11'd0;
    end

    always_comb begin
        logic [62:0] sum;
        logic        inc;
        logic [63:0] upper;
        inc = r_s6.grd & (r_s6.stk | r_s6.trunc[0]);
        sum = {r_s6.ebase, 52'b0} + {10'b0, r_s6.trunc} + {62'b0, inc};
        upper = {r_s6.word[31:2], 2'b00, 32'b0};
        if (!r_s6.scale) begin
            n_bits = r_s6.plain;
        end else if (r_s6.nan) begin
            n_bits = upper | QUIET_BIT;
        end else if (r_s6.inf) begin
            n_bits = upper;
        end else if (r_s6.zero) begin
            n_bits = {r_s6.sign, 63'b0};
        end else begin
            n_bits = {r_s6.sign, sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v6 <= i_ctl.valid;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s6   <= n_s6;
            r_bits <= n_bits;
        end
    end

    assign o_valid = r_v7;
    assign o_bits  = r_bits;

endmodule

// File: rtl/core/rk_number_decode.sv
// Top level of the RK number decoder: seven-stage pipeline from RK word to binary64.
//
//   channel  direction  tdata fields (low bit up)
//   s_*      in         rk_word[31:0]
//   m_*      out        value_bits[63:0]
//
// One beat is accepted per cycle while the output is not stalled.
// The constant multiply is split into two partial products.
// Reset clears the stage valid bits only.
// A stall on the output freezes every stage together, so nothing is lost or repeated.
module rk_number_decode
    import rkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rk_word[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // value_bits[63:0]
);

    logic en;
    logic v_unpack, v_mul;
    t_num num_unpack, num_mul;
    t_ctl ctl_in, ctl_mul, ctl_round;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    assign ctl_in    = '{en: en, valid: s_tvalid};
    assign ctl_mul   = '{en: en, valid: v_unpack};
    assign ctl_round = '{en: en, valid: v_mul};

    rkd_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_word  (s_tdata),
        .o_valid (v_unpack),
        .o_num   (num_unpack)
    );

    rkd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_mul),
        .i_num   (num_unpack),
        .o_valid (v_mul),
        .o_num   (num_mul)
    );

    rkd_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_round),
        .i_num   (num_mul),
        .o_valid (m_tvalid),
        .o_bits  (m_tdata)
    );

endmodule

// File: tb/tb_rk_number_decode.sv
// Self-checking testbench for the RK number decoder: directed and random RK words.
module tb_rk_number_decode;
    import rkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 480;
    localparam int HOLD_LEN   = 300;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // rk_word[31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // value_bits[63:0]

    logic [31:0] pending_words[$];
    logic [63:0] expected_vals[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;
    int          mismatches = 0;
    int          words_sent = 0;
    int          values_seen = 0;
    int          quiet_cnt = 0;

    rk_number_decode dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Decodes an RK word into the binary64 pattern of its value.
    function automatic logic [63:0] rk_to_f64(input logic [31:0] w);
        logic [63:0] b;
        int          v;
        if (w[FLAG_INT]) begin
            v = int'($signed(w[31:2]));
            b = $realtobits(real'(v));
        end else begin
            b = {w[31:2], 2'b00, 32'h0};
        end
        if (w[FLAG_SCALE]) begin
            if (b[62:52] == 11'h7FF && b[51:0] != '0)
                b = b | QUIET_BIT;
            else
                b = $realtobits($bitstoreal(b) * 0.01);
        end
        return b;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[31:2] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 9'h000, w[21:2]};
            1: w[30:20] = 11'h7FF;
            2: w[30:20] = 11'h000;
            3: w[31:2] = $urandom_range(0, 1) ? 30'h1FFFFFFF : 30'h20000000;
            4: w[31:2] = {{20{w[31]}}, w[11:2]};
            5: w[30:20] = 11'h3FF - 11'($urandom_range(0, 40));
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_vals.push_back(rk_to_f64(s_tdata));
                words_sent++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (pending_words.size() > 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("mismatch at %0t: value_bits %h, expected %h", $time, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                values_seen++;
                if (expected_vals.size() == 0)
                    report_mismatch(m_tdata, 'x);
                else if (m_tdata !== expected_vals[0])
                    report_mismatch(m_tdata, expected_vals.pop_front());
                else
                    void'(expected_vals.pop_front());
            end
            if (hold_req && hold_cnt == 0) begin
                hold_req <= 1'b0;
                hold_cnt <= HOLD_LEN;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= (hold_cnt == 1);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet_cnt);
            $display("tb_rk_number_decode failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_vals.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] directed[] = '{
            32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
            32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0002, 32'h8000_0003,
            32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h7FF0_0000, 32'h7FF0_0001,
            32'hFFF0_0001, 32'h7FF8_0000, 32'h7FF0_0010, 32'hFFF0_0011,
            32'h0000_0004, 32'h0000_0005, 32'h8000_0005, 32'h000F_FFFD,
            32'h0010_0001, 32'h3FF0_0000, 32'h3FF0_0001, 32'h7FEF_FFFC,
            32'h7FEF_FFFD};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 48;
        foreach (directed[k])
            pending_words.push_back(directed[k]);
        wait_drained();
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 36;
            end
            if (k == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pending_words.push_back(random_word());
            if (k == 40) begin
                hold_req = 1'b1;
                repeat (10) pending_words.push_back(random_word());
            end
            if (k % 20 == 19)
                while (pending_words.size() > 4)
                    @(posedge i_clk);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d RK words (integer, float, subnormal, infinity, NaN, scaled)",
                 words_sent);
        $display("checked %0d values under three idle mixes and a long output stall",
                 values_seen);
        if (mismatches == 0 && expected_vals.size() == 0) begin
            $display("tb_rk_number_decode passed");
        end else begin
            $display("tb_rk_number_decode failed");
        end
        $finish;
    end

endmodule
